// ----- hdl/cfrx_pkg.sv -----
package cfrx_pkg;

  // Ring geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  // Frame field widths
  localparam int unsigned ID_W    = 11;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned DATA_W  = 64;
  localparam int unsigned ENTRY_W = ID_W + LEN_W;
  localparam int unsigned FILL_W  = 5;
  localparam int unsigned DROP_W  = 16;
  localparam int unsigned BYTES   = DATA_W / 8;

  localparam logic [LEN_W-1:0]  MAX_LEN  = LEN_W'(BYTES);
  localparam logic [DROP_W-1:0] DROP_MAX = '1;

  typedef enum logic {
    ACT_PUSH = 1'b0,
    ACT_POP  = 1'b1
  } action_e;

  // Accepted transaction, decoded
  typedef struct packed {
    logic push;
    logic pop;
  } cmd_t;

  // Memory access issued by the pointer control
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Occupancy and drop statistics
  typedef struct packed {
    logic [CNT_W-1:0]  held;
    logic [DROP_W-1:0] drops;
  } stat_t;

  // Lengths above eight bytes clamp to eight
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    sat_len = (len > MAX_LEN) ? MAX_LEN : len;
  endfunction

  // Keep bytes below the length, zero the rest
  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < BYTES; i++) begin
      if (LEN_W'(i) < len) begin
        m[i*8 +: 8] = 8'hFF;
      end
    end
    byte_mask = m;
  endfunction

endpackage

// ----- hdl/can_frame_rx_ring_drop_oldest.sv -----
// Receive queue for standard CAN frames, sixteen entries deep. A push stores
// identifier, length (clamped to eight) and data; on a full ring the oldest
// frame is overwritten and the saturating overflow count goes up. A pop
// returns the oldest frame with pop_valid set, data bytes past the length
// zeroed, or pop_valid clear when empty. Every transaction gives one result
// that also carries fill level and overflow count after it. The frame memory
// has a registered read and the result is registered behind it. Input stall
// stays high while a read is in flight or a result waits under out_stall_i, so
// no new transaction is taken before the last one has been read. No clearing
// pass runs after reset; the block accepts input right away.
module can_frame_rx_ring_drop_oldest import cfrx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic [ID_W-1:0]   frame_id_i,
  input  logic [LEN_W-1:0]  frame_len_i,
  input  logic [DATA_W-1:0] frame_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              pop_valid_o,
  output logic [ID_W-1:0]   out_id_o,
  output logic [LEN_W-1:0]  out_len_o,
  output logic [DATA_W-1:0] out_data_o,
  output logic [FILL_W-1:0] fill_level_o,
  output logic [DROP_W-1:0] overflow_total_o
);

  logic               accept;
  cmd_t               cmd;
  mem_req_t           mem_req;
  stat_t              stat;
  logic [ENTRY_W-1:0] entry_rd;
  logic [DATA_W-1:0]  data_rd;
  logic [LEN_W-1:0]   entry_len;

  logic               pend_q, pend_d;
  logic               hit_q, hit_d;
  logic               out_valid_q, out_valid_d;
  logic               pop_valid_q;
  logic [ID_W-1:0]    out_id_q;
  logic [LEN_W-1:0]   out_len_q;
  logic [DATA_W-1:0]  out_data_q;
  logic [FILL_W-1:0]  fill_q;
  logic [DROP_W-1:0]  drops_q;

  // Input handshake: hold off while a read is in flight or the result waits
  assign in_stall_o = pend_q || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign cmd.push = accept && (action_i == ACT_PUSH);
  assign cmd.pop  = accept && (action_i == ACT_POP);

  cfrx_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .mem_req_o (mem_req),
    .stat_o    (stat)
  );

  // Identifier and length store
  cfrx_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_id_len_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i ({sat_len(frame_len_i), frame_id_i}),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (entry_rd)
  );

  // Data byte store
  cfrx_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (frame_data_i),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (data_rd)
  );

  assign entry_len = entry_rd[ENTRY_W-1:ID_W];

  // Sequencing: result is built the cycle after acceptance
  always_comb begin
    pend_d      = accept;
    hit_d       = mem_req.re;
    out_valid_d = pend_q || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      pop_valid_q <= hit_q;
      out_id_q    <= hit_q ? entry_rd[ID_W-1:0] : '0;
      out_len_q   <= hit_q ? entry_len : '0;
      out_data_q  <= hit_q ? (data_rd & byte_mask(entry_len)) : '0;
      fill_q      <= FILL_W'(stat.held);
      drops_q     <= stat.drops;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pop_valid_o      = pop_valid_q;
  assign out_id_o         = out_id_q;
  assign out_len_o        = out_len_q;
  assign out_data_o       = out_data_q;
  assign fill_level_o     = fill_q;
  assign overflow_total_o = drops_q;

  // A read is never in flight while a new transaction is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o)
    else $error("transaction accepted while previous one in flight");

  // Occupancy never exceeds ring depth
  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.held <= CNT_W'(DEPTH))
    else $error("held count above depth");

  // A pop on an empty ring returns no frame
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.pop && (stat.held == '0) |=> ##1 (out_valid_o && !pop_valid_o))
    else $error("pop on empty ring returned a frame");

  // Returned frames never exceed eight bytes
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pop_valid_o |-> out_len_o <= MAX_LEN)
    else $error("popped length above eight");

endmodule

// ----- hdl/cfrx_ram.sv -----
module cfrx_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/cfrx_ctrl.sv -----
module cfrx_ctrl import cfrx_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cmd_t     cmd_i,
  output mem_req_t mem_req_o,
  output stat_t    stat_o
);

  logic [ADDR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [ADDR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  held_q, held_d;
  logic [DROP_W-1:0] drops_q, drops_d;
  logic              full;
  logic              not_empty;

  function automatic logic [ADDR_W-1:0] next_ptr(input logic [ADDR_W-1:0] p);
    next_ptr = (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full      = (held_q == CNT_W'(DEPTH));
  assign not_empty = (held_q != '0);

  // Pointer and counter update for one transaction
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    held_d   = held_q;
    drops_d  = drops_q;
    if (cmd_i.push) begin
      wr_ptr_d = next_ptr(wr_ptr_q);
      if (full) begin
        // ring full: oldest frame is overwritten
        rd_ptr_d = next_ptr(rd_ptr_q);
        if (drops_q != DROP_MAX) begin
          drops_d = drops_q + 1'b1;
        end
      end else begin
        held_d = held_q + 1'b1;
      end
    end else if (cmd_i.pop && not_empty) begin
      rd_ptr_d = next_ptr(rd_ptr_q);
      held_d   = held_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      held_q   <= '0;
      drops_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      held_q   <= held_d;
      drops_q  <= drops_d;
    end
  end

  // Memory access for this transaction
  assign mem_req_o.we    = cmd_i.push;
  assign mem_req_o.waddr = wr_ptr_q;
  assign mem_req_o.re    = cmd_i.pop && not_empty;
  assign mem_req_o.raddr = rd_ptr_q;

  assign stat_o.held  = held_q;
  assign stat_o.drops = drops_q;

endmodule

// ----- tb/can_frame_rx_ring_drop_oldest_tb.sv -----
`timescale 1ns / 100ps

module can_frame_rx_ring_drop_oldest_tb import cfrx_pkg::*;;

  // Generous guard: ~1k transactions, each worst case gap plus read and stall, many times over
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned SETTLE_CYCLES = 8;

  // One result transaction as seen on the output channel
  typedef struct packed {
    logic              pop_valid;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    logic [FILL_W-1:0] fill;
    logic [DROP_W-1:0] drops;
  } ring_result_t;

  // Shadow ring plus queue of results still owed by the block
  class frame_ring_scoreboard;
    logic [ENTRY_W-1:0] id_len_mem [DEPTH];
    logic [DATA_W-1:0]  data_mem [DEPTH];
    int unsigned        wr_idx;
    int unsigned        rd_idx;
    int unsigned        held;
    logic [DROP_W-1:0]  drops;
    ring_result_t       owed_q [$];
    int unsigned        mismatches;
    int unsigned        results_seen;

    function new();
      wr_idx = 0;
      rd_idx = 0;
      held = 0;
      drops = '0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function int unsigned bump(int unsigned idx);
      return (idx == DEPTH - 1) ? 0 : idx + 1;
    endfunction

    function logic [DATA_W-1:0] keep_bytes(logic [LEN_W-1:0] n);
      if (n >= BYTES) return '1;
      return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Apply an accepted transaction to the shadow ring and queue its result
    function void note_frame(action_e act, logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                             logic [DATA_W-1:0] data);
      ring_result_t       r;
      logic [LEN_W-1:0]   kept_len;
      logic [ENTRY_W-1:0] entry;
      r = '0;
      if (act == ACT_PUSH) begin
        kept_len = (len > MAX_LEN) ? MAX_LEN : len;
        // full ring: oldest frame is dropped, count holds
        if (held == DEPTH) begin
          rd_idx = bump(rd_idx);
          if (drops != {DROP_W{1'b1}}) drops = drops + 1'b1;
        end else begin
          held++;
        end
        id_len_mem[wr_idx] = {kept_len, id};
        data_mem[wr_idx] = data;
        wr_idx = bump(wr_idx);
      end else if (held != 0) begin
        entry = id_len_mem[rd_idx];
        r.pop_valid = 1'b1;
        r.id = entry[ID_W-1:0];
        r.len = entry[ENTRY_W-1:ID_W];
        r.data = data_mem[rd_idx] & keep_bytes(r.len);
        rd_idx = bump(rd_idx);
        held--;
      end
      r.fill = FILL_W'(held);
      r.drops = drops;
      owed_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("mismatch @%0t result %0d: %s", $realtime, results_seen, msg);
      mismatches++;
    endtask

    // Compare one delivered result against the oldest owed one
    task check_result(ring_result_t got);
      ring_result_t want;
      if (owed_q.size() == 0) begin
        report_mismatch("result with nothing outstanding");
      end else begin
        want = owed_q.pop_front();
        if (got.pop_valid !== want.pop_valid)
          report_mismatch($sformatf("pop_valid %b want %b", got.pop_valid, want.pop_valid));
        if (got.id !== want.id)
          report_mismatch($sformatf("out_id %h want %h", got.id, want.id));
        if (got.len !== want.len)
          report_mismatch($sformatf("out_len %0d want %0d", got.len, want.len));
        if (got.data !== want.data)
          report_mismatch($sformatf("out_data %h want %h", got.data, want.data));
        if (got.fill !== want.fill)
          report_mismatch($sformatf("fill_level %0d want %0d", got.fill, want.fill));
        if (got.drops !== want.drops)
          report_mismatch($sformatf("overflow_total %0d want %0d", got.drops, want.drops));
      end
      results_seen++;
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic              action_i;
  logic [ID_W-1:0]   frame_id_i;
  logic [LEN_W-1:0]  frame_len_i;
  logic [DATA_W-1:0] frame_data_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              pop_valid_o;
  logic [ID_W-1:0]   out_id_o;
  logic [LEN_W-1:0]  out_len_o;
  logic [DATA_W-1:0] out_data_o;
  logic [FILL_W-1:0] fill_level_o;
  logic [DROP_W-1:0] overflow_total_o;

  frame_ring_scoreboard sb;
  ring_result_t         observed;
  bit                   hold_off_req;
  bit                   stall_free;

  can_frame_rx_ring_drop_oldest dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .frame_id_i       (frame_id_i),
    .frame_len_i      (frame_len_i),
    .frame_data_i     (frame_data_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pop_valid_o      (pop_valid_o),
    .out_id_o         (out_id_o),
    .out_len_o        (out_len_o),
    .out_data_o       (out_data_o),
    .fill_level_o     (fill_level_o),
    .overflow_total_o (overflow_total_o)
  );

  // 2 ns clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Runaway guard
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Result side stall: own pattern, long hold-off on request, open during push streaks
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    int unsigned hold_left;
    mode = 0;
    span = 0;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && hold_off_req) begin
        hold_left = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left != 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (stall_free) begin
        out_stall_i = 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(4, 60);
        end
        span--;
        case (mode)
          0: out_stall_i = 1'b0;
          1: out_stall_i = ($urandom_range(0, 3) == 0);
          2: out_stall_i = ($urandom_range(0, 1) == 1);
          default: out_stall_i = span[1];
        endcase
      end
    end
  end

  // Output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      observed.pop_valid = pop_valid_o;
      observed.id = out_id_o;
      observed.len = out_len_o;
      observed.data = out_data_o;
      observed.fill = fill_level_o;
      observed.drops = overflow_total_o;
      sb.check_result(observed);
    end
  end

  // Offer one transaction and hold it until the block takes it
  task automatic send_frame(action_e act, logic [ID_W-1:0] id, logic [LEN_W-1:0] len,
                            logic [DATA_W-1:0] data);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    action_i = act;
    frame_id_i = id;
    frame_len_i = len;
    frame_data_i = data;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_frame(act, id, len, data);
  endtask

  task automatic sender_gap(int unsigned n);
    if (n == 0) return;
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // Let every owed result come back, then settle with the input idle
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_random_frame(int unsigned push_pct);
    action_e           act;
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
    act = ($urandom_range(0, 99) < push_pct) ? ACT_PUSH : ACT_POP;
    case ($urandom_range(0, 9))
      0: id = '0;
      1: id = '1;
      default: id = ID_W'($urandom());
    endcase
    // mostly legal lengths, some above eight to hit the clamp
    len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom_range(9, 15))
                                      : LEN_W'($urandom_range(0, 8));
    data = ($urandom_range(0, 15) == 0) ? '1 : {$urandom(), $urandom()};
    send_frame(act, id, len, data);
  endtask

  // Bursts with a random push bias so fill swings between empty and overflowing
  task automatic random_traffic(int unsigned count);
    int unsigned sent;
    int unsigned burst;
    int unsigned push_pct;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      case ($urandom_range(0, 2))
        0: push_pct = 85;
        1: push_pct = 50;
        default: push_pct = 25;
      endcase
      repeat (burst) begin
        send_random_frame(push_pct);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) sender_gap($urandom_range(1, 12));
    end
  endtask

  initial begin : stimulus
    sb = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = 1'b0;
    frame_id_i = '0;
    frame_len_i = '0;
    frame_data_i = '0;
    hold_off_req = 1'b0;
    stall_free = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty pop, length extremes and clamp, id extremes
    send_frame(ACT_POP, '0, '0, '0);
    send_frame(ACT_PUSH, '0, 4'd0, '1);
    send_frame(ACT_PUSH, '1, 4'd8, '1);
    send_frame(ACT_PUSH, 11'h555, 4'd15, 64'h0123_4567_89AB_CDEF);
    send_frame(ACT_PUSH, 11'h2AA, 4'd9, 64'hA5A5_5A5A_F00F_0FF0);
    send_frame(ACT_PUSH, 11'h001, 4'd4, '1);
    send_frame(ACT_PUSH, 11'h400, 4'd1, 64'hFFFF_FFFF_FFFF_FF80);
    repeat (6) send_frame(ACT_POP, '1, '1, '1);
    send_frame(ACT_POP, '0, '0, '0);
    wait_drained();

    random_traffic(280);

    // Result side held off while input keeps coming: block must back up
    hold_off_req = 1'b1;
    repeat (48) send_random_frame(70);
    wait_drained();

    random_traffic(280);
    wait_drained();
    random_traffic(280);
    wait_drained();

    // Push streak with the result side open: ring overflows, then mixed traffic
    stall_free = 1'b1;
    repeat (20) send_random_frame(100);
    repeat (20) send_random_frame(30);
    stall_free = 1'b0;
    random_traffic(60);

    wait_drained();
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/cfrx_pkg.sv
hdl/cfrx_ram.sv
hdl/cfrx_ctrl.sv
hdl/can_frame_rx_ring_drop_oldest.sv
tb/can_frame_rx_ring_drop_oldest_tb.sv
